// ===== rtl/ntps_pkg.sv =====
// ============================================================================
// ntps_pkg
// Shared types, constants and helpers for the neighbor table parent select
// engine.
// ============================================================================
package ntps_pkg;

    // Table geometry.
    localparam int TABLE_ENTRIES = 16;
    localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int SLOT_W        = 6;

    // Channel window in the channel mask (bit c names channel c).
    localparam int CHAN_FIRST = 11;
    localparam int CHAN_LAST  = 26;
    localparam int CHAN_COUNT = CHAN_LAST - CHAN_FIRST + 1;
    localparam int CHAN_W     = 5;

    // Command codes.
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_SELECT = 1'b1;

    // Status codes.
    localparam logic [2:0] STAT_INSERTED = 3'd0;
    localparam logic [2:0] STAT_PRESENT  = 3'd1;
    localparam logic [2:0] STAT_FULL     = 3'd2;
    localparam logic [2:0] STAT_FOUND    = 3'd3;
    localparam logic [2:0] STAT_NONE     = 3'd4;

    // One table entry as stored in the RAM.
    typedef struct packed {
        logic [7:0]  quality;
        logic [15:0] pan;
        logic [15:0] address;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_DONE
    } state_t;

    // Lowest channel whose bit is set in the channel window, zero if none.
    function automatic logic [CHAN_W-1:0] lowest_channel(
        input logic [CHAN_COUNT-1:0] bits
    );
        logic [CHAN_W-1:0] ch;
        ch = '0;
        for (int i = CHAN_COUNT - 1; i >= 0; i--) begin
            if (bits[i])
            begin
                ch = CHAN_W'(CHAN_FIRST + i);
            end
        end
        return ch;
    endfunction

endpackage

// ===== rtl/ntps_ram.sv =====
// ============================================================================
// ntps_ram
// Generic single-write, single-read RAM with a registered read port.
// ============================================================================
module ntps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/neighbor_table_parent_select_core.sv =====
// ============================================================================
// neighbor_table_parent_select_core
// Neighbor table engine: beacon insert and best-link-quality parent select.
// ============================================================================
// Every command item walks the whole neighbor table, which lives in one RAM
// with a registered read port. One entry is read per cycle. An item is taken
// in the idle state; the scan state then reads each entry in turn, the drain
// state waits for the last read data to come back, and the done state writes
// the new entry and loads the result into the output register. The done
// state waits while the output register holds a result that is not taken.
// A new item is accepted as soon as the engine is back in idle, even while
// the previous result still waits in the output register. A per-entry valid
// bit, cleared at reset, makes never-written entries read as empty (all
// zero), so no clearing pass follows reset.
// ============================================================================
module neighbor_table_parent_select_core
    import ntps_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // Command items.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata, low bit up: short_address[15:0], pan_id[31:16],
    // link_quality[39:32], channel_mask[71:40].
    input  logic [71:0] s_axis_tdata,
    // tuser: command[0].
    input  logic [0:0]  s_axis_tuser,
    // Result items.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata, low bit up: parent_address[15:0], parent_slot[21:16],
    // join_channel[26:22], zero fill [31:27].
    output logic [31:0] m_axis_tdata,
    // tuser: status[2:0].
    output logic [2:0]  m_axis_tuser
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    // Control flow.
    state_t state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic proc_vld_reg, proc_vld_next;
    logic [IDX_W-1:0] proc_idx_reg, proc_idx_next;
    logic [TABLE_ENTRIES-1:0] vld_reg, vld_next;
    logic out_valid_reg, out_valid_next;

    // Command held for the duration of the scan.
    logic cmd_reg, cmd_next;
    logic [15:0] addr_reg, addr_next;
    logic [15:0] pan_reg, pan_next;
    logic [7:0] lqi_reg, lqi_next;
    logic [CHAN_COUNT-1:0] mask_reg, mask_next;

    // Scan accumulators. For an insert, found marks the first free slot; for
    // a select it marks the best candidate so far.
    logic present_reg, present_next;
    logic found_reg, found_next;
    logic [IDX_W-1:0] slot_reg, slot_next;
    logic [15:0] best_addr_reg, best_addr_next;
    logic [7:0] best_lqi_reg, best_lqi_next;

    // Output register.
    logic [2:0] out_status_reg, out_status_next;
    logic [15:0] out_addr_reg, out_addr_next;
    logic [SLOT_W-1:0] out_slot_reg, out_slot_next;
    logic [CHAN_W-1:0] out_chan_reg, out_chan_next;

    // Control strobes.
    logic accept;
    logic rd_en;
    logic load_out;
    logic wr_en;

    // RAM side.
    entry_t rd_data;
    entry_t wr_data;
    entry_t cur;

    ntps_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (slot_reg),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (idx_reg),
        .rd_data (rd_data)
    );

    assign wr_data = '{quality: lqi_reg, pan: pan_reg, address: addr_reg};

    // An entry that was never written reads as empty.
    assign cur = vld_reg[proc_idx_reg] ? rd_data : '0;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (idx_reg == LAST_IDX)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control outputs of the state machine.
    always_comb
    begin
        s_axis_tready = 1'b0;
        rd_en         = 1'b0;
        load_out      = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                s_axis_tready = 1'b1;
            end
            S_SCAN:
            begin
                rd_en = 1'b1;
            end
            S_DRAIN:
            begin
            end
            S_DONE:
            begin
                load_out = !out_valid_reg || m_axis_tready;
            end
            default:
            begin
            end
        endcase
    end

    assign accept = s_axis_tvalid && s_axis_tready;
    assign wr_en  = load_out && (cmd_reg == CMD_INSERT) && !present_reg && found_reg;

    // Datapath.
    always_comb
    begin
        idx_next       = idx_reg;
        proc_vld_next  = rd_en;
        proc_idx_next  = idx_reg;
        vld_next       = vld_reg;
        out_valid_next = out_valid_reg;

        cmd_next  = cmd_reg;
        addr_next = addr_reg;
        pan_next  = pan_reg;
        lqi_next  = lqi_reg;
        mask_next = mask_reg;

        present_next   = present_reg;
        found_next     = found_reg;
        slot_next      = slot_reg;
        best_addr_next = best_addr_reg;
        best_lqi_next  = best_lqi_reg;

        out_status_next = out_status_reg;
        out_addr_next   = out_addr_reg;
        out_slot_next   = out_slot_reg;
        out_chan_next   = out_chan_reg;

        if (accept)
        begin
            cmd_next       = s_axis_tuser[0];
            addr_next      = s_axis_tdata[15:0];
            pan_next       = s_axis_tdata[31:16];
            lqi_next       = s_axis_tdata[39:32];
            mask_next      = s_axis_tdata[40 + CHAN_LAST:40 + CHAN_FIRST];
            idx_next       = '0;
            present_next   = 1'b0;
            found_next     = 1'b0;
            slot_next      = '0;
            best_addr_next = '0;
            best_lqi_next  = '0;
        end

        if (rd_en)
        begin
            idx_next = idx_reg + 1'b1;
        end

        // One entry of read data is folded in per cycle.
        if (proc_vld_reg)
        begin
            if (cmd_reg == CMD_INSERT)
            begin
                if (cur.address == addr_reg && cur.pan == pan_reg)
                begin
                    present_next = 1'b1;
                end
                if (!found_reg && cur.address == 16'd0)
                begin
                    found_next = 1'b1;
                    slot_next  = proc_idx_reg;
                end
            end
            else
            begin
                if (cur.pan != 16'd0 && cur.address != 16'd0 && cur.pan == pan_reg)
                begin
                    // Strictly greater, so the earliest entry keeps a tie.
                    if (!found_reg || best_lqi_reg < cur.quality)
                    begin
                        found_next     = 1'b1;
                        slot_next      = proc_idx_reg;
                        best_addr_next = cur.address;
                        best_lqi_next  = cur.quality;
                    end
                end
            end
        end

        if (wr_en)
        begin
            vld_next[slot_reg] = 1'b1;
        end

        if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        if (load_out)
        begin
            out_valid_next = 1'b1;
            out_addr_next  = '0;
            out_slot_next  = '0;
            out_chan_next  = '0;
            if (cmd_reg == CMD_INSERT)
            begin
                if (present_reg)
                begin
                    out_status_next = STAT_PRESENT;
                end
                else if (!found_reg)
                begin
                    out_status_next = STAT_FULL;
                end
                else
                begin
                    out_status_next = STAT_INSERTED;
                    out_slot_next   = SLOT_W'(slot_reg);
                end
            end
            else
            begin
                out_chan_next = lowest_channel(mask_reg);
                if (found_reg)
                begin
                    out_status_next = STAT_FOUND;
                    out_addr_next   = best_addr_reg;
                    out_slot_next   = SLOT_W'(slot_reg);
                end
                else
                begin
                    out_status_next = STAT_NONE;
                end
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            proc_vld_reg  <= 1'b0;
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            proc_vld_reg  <= proc_vld_next;
            vld_reg       <= vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        proc_idx_reg   <= proc_idx_next;
        cmd_reg        <= cmd_next;
        addr_reg       <= addr_next;
        pan_reg        <= pan_next;
        lqi_reg        <= lqi_next;
        mask_reg       <= mask_next;
        present_reg    <= present_next;
        found_reg      <= found_next;
        slot_reg       <= slot_next;
        best_addr_reg  <= best_addr_next;
        best_lqi_reg   <= best_lqi_next;
        out_status_reg <= out_status_next;
        out_addr_reg   <= out_addr_next;
        out_slot_reg   <= out_slot_next;
        out_chan_reg   <= out_chan_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tdata  = {5'd0, out_chan_reg, out_slot_reg, out_addr_reg};

endmodule

// ===== rtl/ntps_checker.sv =====
// ============================================================================
// ntps_checker
// Port-level assertions for the neighbor table parent select engine.
// ============================================================================
module ntps_checker
    import ntps_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser
);

    // A stalled result holds its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // The engine works on one item at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("item accepted while busy");

    // Only inserted and found results carry a slot; only found carries an address.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser != STAT_FOUND && m_axis_tuser != STAT_INSERTED |->
            m_axis_tdata[21:0] == 22'd0)
        else $error("slot or address set without a match");

    // A found parent never has the empty address.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == STAT_FOUND |-> m_axis_tdata[15:0] != 16'd0)
        else $error("parent found with empty address");

    // Insert results carry no channel, and any channel lies in the window.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[26:22] != 5'd0 |->
            (m_axis_tuser == STAT_FOUND || m_axis_tuser == STAT_NONE) &&
            m_axis_tdata[26:22] >= 5'(CHAN_FIRST) && m_axis_tdata[26:22] <= 5'(CHAN_LAST))
        else $error("bad join channel");

endmodule

bind neighbor_table_parent_select_core ntps_checker u_ntps_checker (.*);

// ===== tb/tb.sv =====
// ============================================================================
// tb
// Self-checking bench for the neighbor table parent select engine.
// ============================================================================
// A table of directed command items runs first: the empty table, the
// duplicate and zero-address beacon cases, tie-breaking on link quality and
// the ends of the channel window. Random traffic follows. Most of it is
// duplicate beacons and parent selects against PAN ids that are really in
// the table. Fresh beacons arrive slowly, so the table fills partway through
// the run and the full-table case gets exercised. A local copy of the
// neighbor table predicts every reply. Replies are checked in order against
// the queue of pending replies.
// ============================================================================
module tb;
    import ntps_pkg::*;

    localparam int HALF_PERIOD   = 6;
    localparam int RESET_CYCLES  = 6;
    localparam int RANDOM_ITEMS  = 1735;
    localparam int LONG_HOLD     = 400;
    localparam int DRAIN_CYCLES  = 40;
    localparam int REPORT_LIMIT  = 10;
    localparam int DIRECTED_ROWS = 16;

    // Expected reply of one command item.
    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] paddr;
        logic [5:0]  slot;
        logic [4:0]  chan;
    } reply_t;

    // One row of the directed stimulus. Rows with typed set carry the reply
    // written out by hand; the others take the reply from the local table.
    typedef struct packed {
        logic        cmd;
        logic [15:0] addr;
        logic [15:0] pan;
        logic [7:0]  lqi;
        logic [31:0] mask;
        logic        typed;
        reply_t      want;
    } probe_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata;
    logic [0:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;

    // Local copy of the neighbor table, all zero after reset.
    logic [15:0] table_addr [TABLE_ENTRIES];
    logic [15:0] table_pan  [TABLE_ENTRIES];
    logic [7:0]  table_lqi  [TABLE_ENTRIES];

    reply_t      pending_replies [$];
    logic [15:0] pan_pool [4];
    probe_t      directed_rows [DIRECTED_ROWS];

    int error_count  = 0;
    int reply_count  = 0;
    bit calm         = 1'b0;
    bit hold_request = 1'b0;

    neighbor_table_parent_select_core i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #HALF_PERIOD clk = ~clk;

    // Safety net: the slowest legal run is far below this.
    initial
    begin
        #(2 * HALF_PERIOD * 900_000);
        $display("tb: done, errors");
        $finish;
    end

    task automatic flag_error(input string what);
        error_count++;
        if (error_count <= REPORT_LIMIT)
        begin
            $display("ERROR: %s", what);
        end
    endtask

    // Applies one command to the local table and returns the reply it causes.
    function automatic reply_t predict_reply(
        input logic        cmd,
        input logic [15:0] addr,
        input logic [15:0] pan,
        input logic [7:0]  lqi,
        input logic [31:0] mask
    );
        reply_t res;
        int     free_slot;
        int     best;
        bit     present;
        res = '0;
        if (cmd == CMD_INSERT)
        begin
            present   = 1'b0;
            free_slot = -1;
            for (int i = 0; i < TABLE_ENTRIES; i++)
            begin
                if (table_addr[i] == addr && table_pan[i] == pan)
                begin
                    present = 1'b1;
                end
                if (free_slot < 0 && table_addr[i] == 16'h0000)
                begin
                    free_slot = i;
                end
            end
            if (present)
            begin
                res.status = STAT_PRESENT;
            end
            else if (free_slot < 0)
            begin
                res.status = STAT_FULL;
            end
            else
            begin
                // A zero address lands here too, but the slot stays free.
                table_addr[free_slot] = addr;
                table_pan[free_slot]  = pan;
                table_lqi[free_slot]  = lqi;
                res.status = STAT_INSERTED;
                res.slot   = 6'(free_slot);
            end
        end
        else
        begin
            best = -1;
            for (int i = 0; i < TABLE_ENTRIES; i++)
            begin
                if (table_pan[i] != 16'h0000 && table_addr[i] != 16'h0000 &&
                    table_pan[i] == pan)
                begin
                    // Strictly greater, so the earliest slot keeps a tie.
                    if (best < 0 || table_lqi[i] > table_lqi[best])
                    begin
                        best = i;
                    end
                end
            end
            if (best < 0)
            begin
                res.status = STAT_NONE;
            end
            else
            begin
                res.status = STAT_FOUND;
                res.paddr  = table_addr[best];
                res.slot   = 6'(best);
            end
            // Scan the window downward so the lowest set channel wins.
            for (int c = CHAN_LAST; c >= CHAN_FIRST; c--)
            begin
                if (mask[c])
                begin
                    res.chan = 5'(c);
                end
            end
        end
        return res;
    endfunction

    // Offers one item, waits for the handshake, records the reply it should
    // cause, then idles for a random gap. The valid is lowered only when a
    // gap follows, so back-to-back items keep it high.
    task automatic send_item(
        input logic        cmd,
        input logic [15:0] addr,
        input logic [15:0] pan,
        input logic [7:0]  lqi,
        input logic [31:0] mask,
        input logic        typed,
        input reply_t      want
    );
        reply_t predicted;
        int     gap;
        int     pick;
        s_axis_tdata  <= {mask, lqi, pan, addr};
        s_axis_tuser  <= cmd;
        s_axis_tvalid <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!s_axis_tready);
        predicted = predict_reply(cmd, addr, pan, lqi, mask);
        pending_replies.push_back(typed ? want : predicted);
        gap  = 0;
        pick = $urandom_range(0, 99);
        if (!calm)
        begin
            if (pick >= 90)
            begin
                gap = $urandom_range(8, 30);
            end
            else if (pick >= 55)
            begin
                gap = $urandom_range(1, 3);
            end
        end
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Result side: random stalls, and one long hold-off on request so the
    // output register and the engine both fill and the input stalls.
    initial
    begin
        int stall_left;
        int pick;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                stall_left   = LONG_HOLD;
            end
            if (stall_left > 0)
            begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                pick = $urandom_range(0, 99);
                if (!calm && rst_n)
                begin
                    if (pick < 25)
                    begin
                        stall_left = $urandom_range(1, 3);
                    end
                    else if (pick < 28)
                    begin
                        stall_left = $urandom_range(10, 40);
                    end
                end
            end
        end
    end

    // Every accepted reply is compared with the oldest pending one.
    always @(posedge clk)
    begin : reply_check
        reply_t got;
        reply_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = '{m_axis_tuser, m_axis_tdata[15:0], m_axis_tdata[21:16],
                    m_axis_tdata[26:22]};
            if (pending_replies.size() == 0)
            begin
                flag_error($sformatf("reply %0d arrived with none pending: status %0d",
                                     reply_count, got.status));
            end
            else
            begin
                want = pending_replies.pop_front();
                if (got.status !== want.status || got.paddr !== want.paddr ||
                    got.slot !== want.slot || got.chan !== want.chan ||
                    m_axis_tdata[31:27] !== 5'b00000)
                begin
                    flag_error($sformatf({"reply %0d: expected status %0d addr %h slot %0d ",
                                          "chan %0d, got status %0d addr %h slot %0d ",
                                          "chan %0d fill %b"},
                                         reply_count, want.status, want.paddr, want.slot,
                                         want.chan, got.status, got.paddr, got.slot,
                                         got.chan, m_axis_tdata[31:27]));
                end
            end
            reply_count++;
        end
    end

    initial
    begin
        logic        cmd;
        logic [15:0] addr;
        logic [15:0] pan;
        logic [7:0]  lqi;
        logic [31:0] mask;
        int          kind;
        int          slot;

        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        m_axis_tready = 1'b0;
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            table_addr[i] = '0;
            table_pan[i]  = '0;
            table_lqi[i]  = '0;
        end
        pan_pool[0] = 16'hFFFF;
        pan_pool[1] = 16'h0001;
        pan_pool[2] = 16'($urandom_range(2, 65534));
        pan_pool[3] = 16'($urandom);

        // Directed rows: cmd, addr, pan, lqi, mask, typed, reply.
        directed_rows[0]  = '{CMD_SELECT, 16'hFFFF, 16'h1234, 8'hFF, 32'hFFFF_FFFF, 1'b1,
                              '{STAT_NONE, 16'h0000, 6'd0, 5'd11}};
        // An empty slot reads as address 0, PAN 0, so this counts as present.
        directed_rows[1]  = '{CMD_INSERT, 16'h0000, 16'h0000, 8'h00, 32'h0000_0000, 1'b1,
                              '{STAT_PRESENT, 16'h0000, 6'd0, 5'd0}};
        directed_rows[2]  = '{CMD_INSERT, 16'hFFFF, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF, 1'b1,
                              '{STAT_INSERTED, 16'h0000, 6'd0, 5'd0}};
        directed_rows[3]  = '{CMD_INSERT, 16'hFFFF, 16'hFFFF, 8'h00, 32'h0000_0000, 1'b1,
                              '{STAT_PRESENT, 16'h0000, 6'd0, 5'd0}};
        // Zero address with a real PAN: written to slot 1, which stays free.
        directed_rows[4]  = '{CMD_INSERT, 16'h0000, 16'h00AA, 8'h09, 32'h0000_0000, 1'b1,
                              '{STAT_INSERTED, 16'h0000, 6'd1, 5'd0}};
        directed_rows[5]  = '{CMD_INSERT, 16'h0001, 16'hFFFF, 8'hFF, 32'h0000_0000, 1'b1,
                              '{STAT_INSERTED, 16'h0000, 6'd1, 5'd0}};
        // Slots 0 and 1 tie on quality; the earlier one must win.
        directed_rows[6]  = '{CMD_SELECT, 16'h0000, 16'hFFFF, 8'h00, 32'hFFFF_FFFF, 1'b1,
                              '{STAT_FOUND, 16'hFFFF, 6'd0, 5'd11}};
        // Wanted PAN zero never matches; top of the channel window.
        directed_rows[7]  = '{CMD_SELECT, 16'h0000, 16'h0000, 8'h00, 32'h0400_0000, 1'b1,
                              '{STAT_NONE, 16'h0000, 6'd0, 5'd26}};
        // PAN 0x00AA was overwritten; mask bits all outside the window.
        directed_rows[8]  = '{CMD_SELECT, 16'h0000, 16'h00AA, 8'h00, 32'hF800_07FF, 1'b1,
                              '{STAT_NONE, 16'h0000, 6'd0, 5'd0}};
        directed_rows[9]  = '{CMD_INSERT, 16'h0002, 16'hFFFF, 8'h00, 32'h0000_0000, 1'b0,
                              '0};
        directed_rows[10] = '{CMD_INSERT, 16'h8000, 16'h0001, 8'h80, 32'h0000_0000, 1'b0,
                              '0};
        directed_rows[11] = '{CMD_INSERT, 16'h4000, 16'h0001, 8'h81, 32'h0000_0000, 1'b0,
                              '0};
        directed_rows[12] = '{CMD_SELECT, 16'h1234, 16'h0001, 8'h55, 32'h0001_0000, 1'b0,
                              '0};
        // Same address under another PAN is a new neighbor.
        directed_rows[13] = '{CMD_INSERT, 16'h4000, 16'h0002, 8'h7F, 32'h0000_0000, 1'b0,
                              '0};
        directed_rows[14] = '{CMD_SELECT, 16'h0000, 16'h0002, 8'h00, 32'h0000_0400, 1'b0,
                              '0};
        directed_rows[15] = '{CMD_SELECT, 16'hFFFF, 16'hFFFF, 8'hFF, 32'h0200_0000, 1'b0,
                              '0};

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < DIRECTED_ROWS; r++)
        begin
            send_item(directed_rows[r].cmd, directed_rows[r].addr, directed_rows[r].pan,
                      directed_rows[r].lqi, directed_rows[r].mask, directed_rows[r].typed,
                      directed_rows[r].want);
        end

        // Random traffic. Fresh beacons are rare, so the table fills slowly
        // and selects keep finding real candidates before and after that.
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 100 == 0)
            begin
                calm = ($urandom_range(0, 3) == 0);
            end
            if (n == 500)
            begin
                // Long hold-off on the result side while items keep coming.
                hold_request = 1'b1;
                calm         = 1'b1;
            end
            if (n == 1100)
            begin
                // Let the engine drain completely before going on.
                s_axis_tvalid <= 1'b0;
                @(posedge clk);
                while (pending_replies.size() != 0) @(posedge clk);
            end

            kind = $urandom_range(0, 99);
            slot = $urandom_range(0, TABLE_ENTRIES - 1);
            cmd  = CMD_INSERT;
            addr = 16'($urandom);
            pan  = pan_pool[$urandom_range(0, 3)];
            lqi  = 8'($urandom);
            mask = $urandom;
            case ($urandom_range(0, 3))
                0: lqi = 8'h00;
                1: lqi = 8'hFF;
                default: ;
            endcase

            if (kind < 55)
            begin
                cmd = CMD_SELECT;
                case ($urandom_range(0, 9))
                    0: pan = 16'h0000;
                    1: pan = 16'($urandom);
                    2, 3: pan = table_pan[slot];
                    default: ;
                endcase
                case ($urandom_range(0, 5))
                    0: mask = 32'h1 << $urandom_range(CHAN_FIRST, CHAN_LAST);
                    1: mask = 32'h0000_0000;
                    2: mask = mask & 32'hF800_07FF;
                    3: mask = mask & (32'hFFFF_FFFF << $urandom_range(CHAN_FIRST, 27));
                    default: ;
                endcase
            end
            else if (kind < 91)
            begin
                // Beacon from a neighbor the table already holds.
                addr = table_addr[slot];
                pan  = table_pan[slot];
            end
            else if (kind < 93)
            begin
                // Fresh neighbor on one of the pool PAN ids.
            end
            else if (kind < 96)
            begin
                addr = 16'h0000;
            end
            else
            begin
                pan = 16'($urandom);
            end
            send_item(cmd, addr, pan, lqi, mask, 1'b0, '0);
        end

        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_replies.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
        begin
            $display("tb: done, clean");
        end
        else
        begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule
